// ===== rtl/core/pdfm_pkg.sv =====
package pdfm_pkg;

   // fixed field widths
   localparam int RATE_W   = 27;
   localparam int FIELD_W  = 16;
   localparam int DUTY_W   = 7;

   // arithmetic constants
   localparam logic [RATE_W-1:0]  RATE_RESET = 27'd8000000;
   localparam logic [6:0]         PERCENT    = 7'd100;
   localparam logic [9:0]         HZ_PER_KHZ = 10'd1000;
   localparam logic [FIELD_W-1:0] FREQ_MAX   = 16'hFFFF;

   // floor(x / 1000) for x below 2^27: multiply by ceil(2^37 / 1000), drop 37 bits
   localparam int                     KHZ_RECIP_W = 28;
   localparam int                     KHZ_SHIFT   = 37;
   localparam logic [KHZ_RECIP_W-1:0] KHZ_RECIP   = 28'd137438954;

   // capture progress within one measurement
   typedef enum logic [1:0] {
      CAP_WAIT_RISE   = 2'd0,
      CAP_WAIT_FALL   = 2'd1,
      CAP_WAIT_SECOND = 2'd2
   } cap_phase_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_FREQ = 3'd1,
      ST_DUTY = 3'd3,
      ST_DONE = 3'd4
   } seq_state_type;

   // capture unit status toward the sequencer
   typedef struct packed {
      logic done;
      logic in_order;
   } cap_status_type;

endpackage

// ===== rtl/core/pdfm_capture.sv =====
module pdfm_capture #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       level,
   output pdfm_pkg::cap_status_type   status,
   output logic [COUNTER_BITS-1:0]    high_time,
   output logic [COUNTER_BITS-1:0]    period_time
);

   logic                       prev_level_ff;
   pdfm_pkg::cap_phase_type    phase_ff;
   pdfm_pkg::cap_phase_type    phase_in;
   logic [COUNTER_BITS-1:0]    tick_ff;
   logic [COUNTER_BITS-1:0]    tick_in;
   logic [COUNTER_BITS-1:0]    rise_ff;
   logic [COUNTER_BITS-1:0]    fall_ff;
   logic                       rise;
   logic                       fall;
   logic                       last_capture;

   // edge detect against the previous item
   assign rise = !prev_level_ff && level;
   assign fall = prev_level_ff && !level;

   // next phase and tick count
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff + COUNTER_BITS'(1);
      last_capture = 1'b0;
      case (phase_ff)
         pdfm_pkg::CAP_WAIT_RISE: begin
            if (rise) phase_in = pdfm_pkg::CAP_WAIT_FALL;
         end
         pdfm_pkg::CAP_WAIT_FALL: begin
            if (fall) phase_in = pdfm_pkg::CAP_WAIT_SECOND;
         end
         pdfm_pkg::CAP_WAIT_SECOND: begin
            if (rise) begin
               phase_in     = pdfm_pkg::CAP_WAIT_RISE;
               tick_in      = '0;
               last_capture = 1'b1;
            end
         end
         default: begin
            phase_in = pdfm_pkg::CAP_WAIT_RISE;
         end
      endcase
   end

   // capture registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b1;
         phase_ff      <= pdfm_pkg::CAP_WAIT_RISE;
         tick_ff       <= '0;
         rise_ff       <= '0;
         fall_ff       <= '0;
      end else if (accept) begin
         prev_level_ff <= level;
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         if (phase_ff == pdfm_pkg::CAP_WAIT_RISE && rise) rise_ff <= tick_ff;
         if (phase_ff == pdfm_pkg::CAP_WAIT_FALL && fall) fall_ff <= tick_ff;
      end
   end

   // third capture uses the current count as the second rise time
   assign status.done     = accept && last_capture;
   assign status.in_order = (rise_ff < fall_ff) && (fall_ff < tick_ff);
   assign high_time       = fall_ff - rise_ff;
   assign period_time     = tick_ff - rise_ff;

endmodule

// ===== rtl/core/pdfm_divider.sv =====
module pdfm_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one restoring step: bring down the next dividend bit
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   // one quotient bit per cycle, msb first
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/pwm_duty_frequency_meter.sv =====
// PWM duty and frequency meter
//
// Each item on the req_ channel is one sample of the PWM pin. A tick counter of
// COUNTER_BITS bits advances once per item and records the first rising edge,
// the following falling edge and the next rising edge. The item that makes
// the third capture produces one item on the rsp_ channel: high time, period,
// frequency in kHz (csr clock rate / period / 1000, floored, saturating) and
// duty in percent; out_of_range is set and the other fields are zero when the
// counter wrapped during the measurement. Other items produce nothing.
// Throughput: items that make no result are taken one per cycle. The result
// item is computed by one shared restoring divider, one quotient bit per cycle,
// over two divisions of NUM_W = max(27, COUNTER_BITS + 7) steps each (clock rate
// by period, then scaled high time by period); the kHz step is a multiply by a
// constant reciprocal. After the third capture req_ready stays low until the
// result is loaded; an out-of-range result skips both divisions.
// A finished result waits in the output register while rsp_ready is low, and
// samples keep being taken meanwhile until the next result is ready to load.
// Reset (synchronous) sets the clock rate register to 8 MHz, clears the
// counter, and assumes the pin was high, so a first rising edge must be seen.
module pwm_duty_frequency_meter #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_signal_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pdfm_pkg::FIELD_W-1:0]         rsp_freq_khz,
   output logic [pdfm_pkg::DUTY_W-1:0]          rsp_duty_percent,
   output logic [pdfm_pkg::FIELD_W-1:0]         rsp_high_ticks,
   output logic [pdfm_pkg::FIELD_W-1:0]         rsp_period_ticks,
   output logic                                 rsp_out_of_range,
   input  logic                                 csr_wr_en,
   input  logic [pdfm_pkg::RATE_W-1:0]          csr_wr_data
);

   localparam int SCALED_W = COUNTER_BITS + 7;
   localparam int NUM_W    = (SCALED_W > pdfm_pkg::RATE_W) ? SCALED_W : pdfm_pkg::RATE_W;
   localparam int DEN_W    = COUNTER_BITS;
   localparam int PROD_W   = pdfm_pkg::RATE_W + pdfm_pkg::KHZ_RECIP_W;
   localparam int KHZ_W    = PROD_W - pdfm_pkg::KHZ_SHIFT;

   pdfm_pkg::seq_state_type          state_ff;
   pdfm_pkg::seq_state_type          state_in;
   logic [pdfm_pkg::RATE_W-1:0]      rate_ff;
   logic [COUNTER_BITS-1:0]          high_ff;
   logic [COUNTER_BITS-1:0]          period_ff;
   logic [pdfm_pkg::FIELD_W-1:0]     freq_ff;
   logic [pdfm_pkg::DUTY_W-1:0]      duty_ff;
   logic                             oor_ff;
   logic                             rsp_valid_ff;
   logic [pdfm_pkg::FIELD_W-1:0]     rsp_freq_ff;
   logic [pdfm_pkg::DUTY_W-1:0]      rsp_duty_ff;
   logic [pdfm_pkg::FIELD_W-1:0]     rsp_high_ff;
   logic [pdfm_pkg::FIELD_W-1:0]     rsp_period_ff;
   logic                             rsp_oor_ff;

   logic                             accept;
   pdfm_pkg::cap_status_type         cap_status;
   logic [COUNTER_BITS-1:0]          cap_high;
   logic [COUNTER_BITS-1:0]          cap_period;
   logic                             div_start;
   logic [NUM_W-1:0]                 div_num;
   logic [DEN_W-1:0]                 div_den;
   logic                             div_done;
   logic [NUM_W-1:0]                 div_quo;
   logic [SCALED_W-1:0]              high_scaled;
   logic [PROD_W-1:0]                khz_product;
   logic [KHZ_W-1:0]                 khz_value;
   logic                             out_free;
   logic                             load_out;

   assign req_ready = (state_ff == pdfm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   pdfm_capture #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .level       (req_signal_level),
      .status      (cap_status),
      .high_time   (cap_high),
      .period_time (cap_period)
   );

   pdfm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo)
   );

   // high time scaled to percent
   assign high_scaled = SCALED_W'(high_ff) * SCALED_W'(pdfm_pkg::PERCENT);

   // hz to khz: the rate quotient fits the rate width, scaled by a rounded-up reciprocal
   assign khz_product = PROD_W'(div_quo[pdfm_pkg::RATE_W-1:0]) * PROD_W'(pdfm_pkg::KHZ_RECIP);
   assign khz_value   = khz_product[PROD_W-1:pdfm_pkg::KHZ_SHIFT];

   // sequencer: next state and divider operands
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = NUM_W'(rate_ff);
      div_den   = DEN_W'(cap_period);
      load_out  = 1'b0;
      case (state_ff)
         pdfm_pkg::ST_IDLE: begin
            if (cap_status.done) begin
               if (cap_status.in_order) begin
                  div_start = 1'b1;
                  state_in  = pdfm_pkg::ST_FREQ;
               end else begin
                  state_in  = pdfm_pkg::ST_DONE;
               end
            end
         end
         pdfm_pkg::ST_FREQ: begin
            div_num = NUM_W'(high_scaled);
            div_den = DEN_W'(period_ff);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = pdfm_pkg::ST_DUTY;
            end
         end
         pdfm_pkg::ST_DUTY: begin
            if (div_done) state_in = pdfm_pkg::ST_DONE;
         end
         pdfm_pkg::ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = pdfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdfm_pkg::ST_IDLE;
         end
      endcase
   end

   // state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdfm_pkg::ST_IDLE;
         rate_ff  <= pdfm_pkg::RATE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) rate_ff <= csr_wr_data;
      end
   end

   // measurement results held between divisions
   always_ff @(posedge clock) begin
      if (state_ff == pdfm_pkg::ST_IDLE && cap_status.done) begin
         high_ff   <= cap_high;
         period_ff <= cap_period;
         oor_ff    <= !cap_status.in_order;
      end
      if (state_ff == pdfm_pkg::ST_FREQ && div_done) begin
         if (khz_value > KHZ_W'(pdfm_pkg::FREQ_MAX)) freq_ff <= pdfm_pkg::FREQ_MAX;
         else freq_ff <= khz_value[pdfm_pkg::FIELD_W-1:0];
      end
      if (state_ff == pdfm_pkg::ST_DUTY && div_done) begin
         duty_ff <= div_quo[pdfm_pkg::DUTY_W-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_oor_ff    <= oor_ff;
         rsp_freq_ff   <= oor_ff ? '0 : freq_ff;
         rsp_duty_ff   <= oor_ff ? '0 : duty_ff;
         rsp_high_ff   <= oor_ff ? '0 : pdfm_pkg::FIELD_W'(high_ff);
         rsp_period_ff <= oor_ff ? '0 : pdfm_pkg::FIELD_W'(period_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_freq_khz     = rsp_freq_ff;
   assign rsp_duty_percent = rsp_duty_ff;
   assign rsp_high_ticks   = rsp_high_ff;
   assign rsp_period_ticks = rsp_period_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule
